>>> design/owr_pkg.sv
// Package for the overwriting ring with offset lookup.
// Holds payload structs, command codes, controller states and control structs.
// No dependencies.
package owr_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int LEN_BITS_DEF = 16;
	localparam int HANDLE_W     = 32;
	localparam int IN_LEN_W     = 16;
	localparam int OFFSET_W     = 20;
	localparam int OUT_LEN_W    = 16;
	localparam int OUT_SLOT_W   = 4;

	typedef enum logic {
		CMD_ADD  = 1'b0,
		CMD_FIND = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [HANDLE_W-1:0]   entry_handle;
		logic [IN_LEN_W-1:0]   entry_length;
		logic [OFFSET_W-1:0]   byte_offset;
	} owr_req_t;

	typedef struct packed {
		logic                  found;
		logic [HANDLE_W-1:0]   hit_handle;
		logic [OUT_LEN_W-1:0]  hit_length;
		logic [OUT_SLOT_W-1:0] hit_slot;
		logic [OUT_LEN_W-1:0]  offset_in_entry;
		logic                  dropped_oldest;
	} owr_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} owr_state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic load_out;
	} owr_ctl_t;

	typedef struct packed {
		logic empty;
		logic hit;
		logic last;
		logic out_busy;
	} owr_sts_t;

endpackage

>>> design/owr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module owr_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/owr_ctrl.sv
// Controller state machine for the overwriting ring.
// Depends on owr_pkg for states and the command and status structs.
module owr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  owr_pkg::cmd_t     req_cmd,
	input  owr_pkg::owr_sts_t sts,
	output owr_pkg::owr_ctl_t ctl
);

	owr_pkg::owr_state_t state_q;
	owr_pkg::owr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= owr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		ctl.start    = 1'b0;
		ctl.step     = 1'b0;
		ctl.load_out = 1'b0;
		unique case (state_q)
			owr_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.start = 1'b1;
					if (req_cmd == owr_pkg::CMD_ADD || sts.empty) begin
						state_d = owr_pkg::ST_DONE;
					end else begin
						state_d = owr_pkg::ST_WALK;
					end
				end
			end
			owr_pkg::ST_WALK: begin
				ctl.step = 1'b1;
				if (sts.hit || sts.last) begin
					state_d = owr_pkg::ST_DONE;
				end
			end
			owr_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					ctl.load_out = 1'b1;
					state_d      = owr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = owr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/owr_dp.sv
// Datapath of the overwriting ring: slot pointers, entry RAM, walk registers
// and the output register. Depends on owr_pkg and owr_ram.
module owr_dp #(
	parameter int DEPTH    = owr_pkg::DEPTH_DEF,
	parameter int LEN_BITS = owr_pkg::LEN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  owr_pkg::owr_req_t req,
	output owr_pkg::owr_rsp_t rsp,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  owr_pkg::owr_ctl_t ctl,
	output owr_pkg::owr_sts_t sts
);

	localparam int SW    = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);
	localparam int RW    = owr_pkg::OFFSET_W;
	localparam int CW    = (LEN_BITS > RW) ? LEN_BITS : RW;
	localparam int DW    = owr_pkg::HANDLE_W + LEN_BITS;

	logic [SW-1:0]       write_slot_q;
	logic [SW-1:0]       read_slot_q;
	logic                full_q;
	logic [SW-1:0]       walk_slot_q;
	logic [CNTW-1:0]     left_q;
	logic [RW-1:0]       rem_q;
	owr_pkg::owr_rsp_t   res_q;
	owr_pkg::owr_rsp_t   rsp_q;
	logic                rsp_valid_q;

	logic [SW-1:0]       write_inc;
	logic [SW-1:0]       read_inc;
	logic [SW-1:0]       walk_inc;
	logic [CNTW-1:0]     count;
	logic [SW-1:0]       raddr;
	logic [DW-1:0]       wdata;
	logic [DW-1:0]       rdata;
	logic [LEN_BITS-1:0] rd_len;
	logic                is_add;
	owr_pkg::owr_rsp_t   start_res;
	owr_pkg::owr_rsp_t   hit_res;

	assign write_inc = (write_slot_q == SW'(DEPTH - 1)) ? '0 : write_slot_q + 1'b1;
	assign read_inc  = (read_slot_q == SW'(DEPTH - 1)) ? '0 : read_slot_q + 1'b1;
	assign walk_inc  = (walk_slot_q == SW'(DEPTH - 1)) ? '0 : walk_slot_q + 1'b1;

	always_comb begin
		if (full_q) begin
			count = CNTW'(DEPTH);
		end else if (write_slot_q >= read_slot_q) begin
			count = CNTW'(write_slot_q) - CNTW'(read_slot_q);
		end else begin
			count = CNTW'(write_slot_q) + CNTW'(DEPTH) - CNTW'(read_slot_q);
		end
	end

	assign is_add = (req.cmd == owr_pkg::CMD_ADD);
	assign raddr  = ctl.step ? walk_inc : read_slot_q;
	assign wdata  = {req.entry_handle, LEN_BITS'(req.entry_length)};
	assign rd_len = rdata[LEN_BITS-1:0];

	always_comb begin
		start_res                 = '0;
		start_res.dropped_oldest  = is_add && full_q;
		hit_res                   = '0;
		hit_res.found             = 1'b1;
		hit_res.hit_handle        = rdata[DW-1:LEN_BITS];
		hit_res.hit_length        = owr_pkg::OUT_LEN_W'(rd_len);
		hit_res.hit_slot          = owr_pkg::OUT_SLOT_W'(walk_slot_q);
		hit_res.offset_in_entry   = owr_pkg::OUT_LEN_W'(rem_q);
	end

	owr_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.start && is_add),
		.waddr(write_slot_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign sts.empty    = (count == '0);
	assign sts.hit      = (CW'(rem_q) < CW'(rd_len));
	assign sts.last     = (left_q == CNTW'(1));
	assign sts.out_busy = rsp_valid_q && !rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			read_slot_q  <= '0;
			full_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (ctl.start && is_add) begin
				write_slot_q <= write_inc;
				if (full_q) begin
					read_slot_q <= read_inc;
				end else if (write_inc == read_slot_q) begin
					full_q <= 1'b1;
				end
			end
			if (ctl.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			res_q       <= start_res;
			rem_q       <= req.byte_offset;
			walk_slot_q <= read_slot_q;
			left_q      <= count;
		end
		if (ctl.step) begin
			if (sts.hit) begin
				res_q <= hit_res;
			end else begin
				rem_q       <= rem_q - RW'(rd_len);
				walk_slot_q <= walk_inc;
				left_q      <= left_q - 1'b1;
			end
		end
		if (ctl.load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (write_slot_q == read_slot_q))
		else $error("ring full with differing slots");

	a_walk_left: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> (left_q != '0))
		else $error("walk step with no entries left");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> !(rsp_valid_q && !rsp_ready))
		else $error("output register overwritten before transfer");

	a_add_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.found && rsp_q.dropped_oldest))
		else $error("result reports both a hit and a drop");

endmodule

>>> design/overwrite_ring_with_offset_lookup.sv
// Top level of the overwriting ring with byte-offset lookup.
// Depends on owr_pkg, owr_ctrl and owr_dp.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  owr_pkg::owr_req_t
//   rsp      out        rsp_valid / rsp_ready  owr_pkg::owr_rsp_t
//
// An add, and a find on an empty ring, go straight to the done state. A find
// otherwise walks the stored entries (at most DEPTH) until one holds the offset
// or none is left: the walk reads one entry per cycle through the single read port of the entry RAM.
// Reset clears the slot pointers, the full flag and the output valid flag; no clearing pass runs.
// A new request is taken while a finished result waits in the output register;
// the next result is held until that transfer happens.
module overwrite_ring_with_offset_lookup #(
	parameter int DEPTH    = owr_pkg::DEPTH_DEF,
	parameter int LEN_BITS = owr_pkg::LEN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  owr_pkg::owr_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output owr_pkg::owr_rsp_t rsp
);

	owr_pkg::owr_ctl_t ctl;
	owr_pkg::owr_sts_t sts;

	owr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_cmd  (req.cmd),
		.sts      (sts),
		.ctl      (ctl)
	);

	owr_dp #(
		.DEPTH   (DEPTH),
		.LEN_BITS(LEN_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.ctl      (ctl),
		.sts      (sts)
	);

endmodule
